>>> hw/rtl/pbrd_pkg.sv
// PackBits row decoder: shared types, codes and constants.
// Used by the parser, emitter, top level and testbench; depends on nothing.
`default_nettype none

package pbrd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ROW_W   = 16;
    localparam int LIMIT_W = ROW_W + 1;
    localparam int CNT_W   = 7;                   // holds 0..CAP_RESULTS

    // Stream codes and limits
    localparam logic [BYTE_W-1:0] NOP_CODE        = 8'h80;
    localparam logic [ROW_W-1:0]  ROW_BYTES_RESET = 16'd320;
    localparam logic [CNT_W-1:0]  CAP_RESULTS     = 7'd64;

    // Default depth of the front-to-back queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // Kind of work handed from front to back
    typedef enum logic {
        CMD_LIT = 1'b0,
        CMD_REP = 1'b1
    } t_cmd_kind;

    // One queued item: literal byte (cnt = bytes left in run after it)
    // or repeat byte (cnt = repeat count, 2..128)
    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] cnt;
    } t_cmd;

    // Front parser state, one-hot
    typedef enum logic [2:0] {
        FS_CTRL = 3'b001,
        FS_LIT  = 3'b010,
        FS_REP  = 3'b100
    } t_front_state;

endpackage : pbrd_pkg

`default_nettype wire

>>> hw/rtl/pbrd_queue.sv
// Small register queue between the parser and the emitter.
// Generic width and depth; no package dependency.
`default_nettype none

module pbrd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_not_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_not_full  = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_rdata     = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule : pbrd_queue

`default_nettype wire

>>> hw/rtl/pbrd_front.sv
// Front parser: takes stream bytes, tracks control/literal/repeat state,
// queues literal and repeat work. Depends on pbrd_pkg.
`default_nettype none

module pbrd_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [7:0]          i_in_byte,
    output logic                     o_push,
    output pbrd_pkg::t_cmd           o_cmd,
    input  wire logic                i_q_not_full
);

    import pbrd_pkg::*;

    t_front_state      r_state, n_state;
    logic [BYTE_W-1:0] r_run_left, n_run_left;
    logic [BYTE_W-1:0] run_dec;
    logic              accept;

    // Control bytes never touch the queue
    assign o_in_ready = (r_state == FS_CTRL) || i_q_not_full;
    assign accept     = i_in_valid && o_in_ready;
    assign run_dec    = r_run_left - 1'b1;

    // Parse and classify one item
    always_comb begin
        n_state    = r_state;
        n_run_left = r_run_left;
        o_push     = 1'b0;
        o_cmd.kind = CMD_LIT;
        o_cmd.data = i_in_byte;
        o_cmd.cnt  = run_dec;
        case (r_state)
            FS_CTRL: begin
                if (accept && i_in_byte != NOP_CODE) begin
                    if (!i_in_byte[BYTE_W-1]) begin
                        n_run_left = i_in_byte + 1'b1;
                        n_state    = FS_LIT;
                    end else begin
                        // 1 - signed byte, 2..128
                        n_run_left = BYTE_W'(9'd257 - {1'b0, i_in_byte});
                        n_state    = FS_REP;
                    end
                end
            end
            FS_LIT: begin
                o_push = accept;
                if (accept) begin
                    n_run_left = run_dec;
                    if (run_dec == '0) begin
                        n_state = FS_CTRL;
                    end
                end
            end
            FS_REP: begin
                o_push     = accept;
                o_cmd.kind = CMD_REP;
                o_cmd.cnt  = r_run_left;
                if (accept) begin
                    n_run_left = '0;
                    n_state    = FS_CTRL;
                end
            end
            default: begin
                n_state = FS_CTRL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_CTRL;
            r_run_left <= '0;
        end else begin
            r_state    <= n_state;
            r_run_left <= n_run_left;
        end
    end

endmodule : pbrd_front

`default_nettype wire

>>> hw/rtl/pbrd_back.sv
// Back emitter: pops queued work, tracks row position, drives the
// result channel one byte per cycle while the receiver is ready. Depends on pbrd_pkg.
`default_nettype none

module pbrd_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [15:0]         i_row_bytes,
    input  wire logic                i_q_not_empty,
    input  wire pbrd_pkg::t_cmd      i_cmd,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_last_of_burst,
    output logic                     o_row_end,
    output logic                     o_overrun
);

    import pbrd_pkg::*;

    logic [ROW_W-1:0]   r_row_pos, n_row_pos;
    logic               r_skip, n_skip;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_rend, n_rend;
    logic               r_ovr, n_ovr;

    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] pos_ext;
    logic [LIMIT_W-1:0] room;
    logic               room_one;
    logic               rep_cut;
    logic [BYTE_W-1:0]  rep_n;
    logic               out_take;

    // Room left in the row; zero length means 65536
    assign limit    = {(i_row_bytes == '0), i_row_bytes};
    assign pos_ext  = {1'b0, r_row_pos};
    assign room     = (pos_ext < limit) ? (limit - pos_ext) : LIMIT_W'(1);
    assign room_one = (room == LIMIT_W'(1));
    assign rep_cut  = ({{(LIMIT_W-BYTE_W){1'b0}}, i_cmd.cnt} >= room);
    assign rep_n    = rep_cut ? room[BYTE_W-1:0] : i_cmd.cnt;

    // Result channel straight from the burst registers
    assign o_out_valid     = (r_cnt != '0);
    assign o_out_byte      = r_byte;
    assign o_last_of_burst = (r_cnt == CNT_W'(1));
    assign o_row_end       = o_last_of_burst && r_rend;
    assign o_overrun       = o_last_of_burst && r_ovr;
    assign out_take        = o_out_valid && i_out_ready;

    // Next work may load once the current burst is done or ending now
    assign o_pop = i_q_not_empty &&
                   ((r_cnt == '0) || (o_last_of_burst && i_out_ready));

    always_comb begin
        n_row_pos = r_row_pos;
        n_skip    = r_skip;
        n_cnt     = out_take ? r_cnt - 1'b1 : r_cnt;
        n_rend    = r_rend;
        n_ovr     = r_ovr;
        if (o_pop) begin
            case (i_cmd.kind)
                CMD_LIT: begin
                    if (r_skip) begin
                        // tail of a literal run cut at the row end
                        n_skip = (i_cmd.cnt != '0);
                    end else begin
                        n_cnt  = CNT_W'(1);
                        n_rend = room_one;
                        n_ovr  = room_one && (i_cmd.cnt != '0);
                        if (room_one) begin
                            n_row_pos = '0;
                            n_skip    = (i_cmd.cnt != '0);
                        end else begin
                            n_row_pos = r_row_pos + 1'b1;
                        end
                    end
                end
                CMD_REP: begin
                    n_rend = rep_cut;
                    n_ovr  = ({{(LIMIT_W-BYTE_W){1'b0}}, i_cmd.cnt} > room);
                    if (rep_n > {1'b0, CAP_RESULTS}) begin
                        n_cnt = CAP_RESULTS;
                        n_ovr = 1'b1;
                    end else begin
                        n_cnt = rep_n[CNT_W-1:0];
                    end
                    n_row_pos = rep_cut ? '0
                                        : r_row_pos + {{(ROW_W-BYTE_W){1'b0}}, rep_n};
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_skip    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_row_pos <= n_row_pos;
            r_skip    <= n_skip;
            r_cnt     <= n_cnt;
        end
    end

    // Burst payload, no reset
    always_ff @(posedge i_clk) begin
        r_rend <= n_rend;
        r_ovr  <= n_ovr;
        if (o_pop) begin
            r_byte <= i_cmd.data;
        end
    end

endmodule : pbrd_back

`default_nettype wire

>>> hw/rtl/packbits_row_decoder.sv
// PackBits row decoder top level: row length register, parser, queue, emitter.
// Depends on pbrd_pkg, pbrd_front, pbrd_queue, pbrd_back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_byte
//  out     | output    | o_out_valid/i_out_ready | o_out_byte, o_last_of_burst,
//          |           |                         | o_row_end, o_overrun
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (row_bytes)
//
// Control bytes yield no output and literal bytes at most one; a repeat byte yields
// up to 64 output bytes, counted out by the emitter's burst counter.
// Input keeps flowing into the queue (QUEUE_DEPTH items) while the emitter
// works or the output stalls. Synchronous active-low reset; row length resets
// to 320 and the decoder to the control state. Config is always ready.
`default_nettype none

module packbits_row_decoder #(
    parameter int QUEUE_DEPTH = pbrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_burst,
    output logic             o_row_end,
    output logic             o_overrun,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    import pbrd_pkg::*;

    logic [ROW_W-1:0] r_row_bytes;
    t_cmd             push_cmd;
    t_cmd             pop_cmd;
    logic             push;
    logic             pop;
    logic             q_not_full;
    logic             q_not_empty;

    // Row length register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_RESET;
        end else if (i_cfg_valid) begin
            r_row_bytes <= i_cfg_data;
        end
    end

    pbrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_q_not_full (q_not_full)
    );

    pbrd_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_wdata     (push_cmd),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_rdata     (pop_cmd),
        .o_not_empty (q_not_empty)
    );

    pbrd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_row_bytes     (r_row_bytes),
        .i_q_not_empty   (q_not_empty),
        .i_cmd           (pop_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_burst (o_last_of_burst),
        .o_row_end       (o_row_end),
        .o_overrun       (o_overrun)
    );

endmodule : packbits_row_decoder

`default_nettype wire

>>> hw/rtl/pbrd_checker.sv
// Port-level checks for the PackBits row decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module pbrd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_burst,
    input wire logic       o_row_end,
    input wire logic       o_overrun
);

    // Nothing to deliver right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Row end only on the last byte of an item's burst
    a_rend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_end) |-> o_last_of_burst)
        else $error("row_end without last_of_burst");

    // Overrun flag only on the last byte of an item's burst
    a_ovr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overrun) |-> o_last_of_burst)
        else $error("overrun without last_of_burst");

    // A burst repeats one byte and continues after a non-last item
    a_burst_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_burst)
        |=> (o_out_valid && o_out_byte == $past(o_out_byte)))
        else $error("burst broken or byte changed");

    // Stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled item dropped or changed");

endmodule : pbrd_checker

bind packbits_row_decoder pbrd_checker u_pbrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_byte      (o_out_byte),
    .o_last_of_burst (o_last_of_burst),
    .o_row_end       (o_row_end),
    .o_overrun       (o_overrun)
);

`default_nettype wire

>>> dv/pbrd_stream_checker.sv
// Stream checker for the PackBits row decoder: predicts decoded bytes from the
// accepted input and config items and compares each accepted output item.
// Depends on pbrd_pkg for the stream codes, the row length reset and the burst cap.

module pbrd_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_of_burst,
    input  logic        i_row_end,
    input  logic        i_overrun,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import pbrd_pkg::*;

    typedef enum logic [1:0] {
        DM_CTRL,
        DM_LIT,
        DM_REP,
        DM_SKIP
    } t_decode_mode;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       row_end;
        logic       overrun;
    } t_decoded_byte;

    t_decoded_byte expected_bytes[$];
    t_decode_mode  mode;
    logic [7:0]    run_left;
    logic [15:0]   row_pos;
    logic [15:0]   row_len;
    int            fail_count;

    // Bytes left before the row closes; a row length of zero means 65536,
    // and a position already at or past the end closes on the next byte.
    function automatic logic [16:0] row_room();
        logic [16:0] limit;
        limit = (row_len == '0) ? 17'd65536 : {1'b0, row_len};
        if ({1'b0, row_pos} < limit)
            return limit - {1'b0, row_pos};
        return 17'd1;
    endfunction

    function automatic void push_expected(logic [7:0] d, logic l, logic r, logic o);
        t_decoded_byte e;
        e.data    = d;
        e.last    = l;
        e.row_end = r;
        e.overrun = o;
        expected_bytes.push_back(e);
    endfunction

    // Advance the decoder by one stream byte and queue what it must emit
    task automatic decode_stream_byte(input logic [7:0] b);
        logic [16:0] room;
        logic [16:0] n;
        int          emit;
        logic        ovr;
        logic        rend;
        case (mode)
            DM_CTRL: begin
                if (b != NOP_CODE) begin
                    if (b < NOP_CODE) begin
                        run_left = 8'(b + 8'd1);
                        mode     = DM_LIT;
                    end else begin
                        run_left = 8'(9'd257 - {1'b0, b});
                        mode     = DM_REP;
                    end
                end
            end
            DM_LIT: begin
                room     = row_room();
                run_left = run_left - 8'd1;
                if (room == 17'd1) begin
                    push_expected(b, 1'b1, 1'b1, run_left != '0);
                    row_pos = '0;
                    mode    = (run_left != '0) ? DM_SKIP : DM_CTRL;
                end else begin
                    push_expected(b, 1'b1, 1'b0, 1'b0);
                    row_pos = row_pos + 16'd1;
                    if (run_left == '0)
                        mode = DM_CTRL;
                end
            end
            DM_REP: begin
                room = row_room();
                n    = {9'b0, run_left};
                ovr  = 1'b0;
                rend = 1'b0;
                // cut at the row end, then at the per-item burst cap
                if (n >= room) begin
                    ovr  = (n > room);
                    n    = room;
                    rend = 1'b1;
                end
                emit = int'(n);
                if (emit > int'(CAP_RESULTS)) begin
                    emit = int'(CAP_RESULTS);
                    ovr  = 1'b1;
                end
                for (int k = 0; k < emit; k++) begin
                    if (k == emit - 1)
                        push_expected(b, 1'b1, rend, ovr);
                    else
                        push_expected(b, 1'b0, 1'b0, 1'b0);
                end
                row_pos  = rend ? '0 : row_pos + n[15:0];
                run_left = '0;
                mode     = DM_CTRL;
            end
            default: begin
                // rest of a literal run past the row end: consumed, no output
                run_left = run_left - 8'd1;
                if (run_left == '0)
                    mode = DM_CTRL;
            end
        endcase
    endtask

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Outputs are checked before the input of the same edge is predicted
    always @(posedge i_clk) begin
        t_decoded_byte e;
        if (!i_rst_n) begin
            mode     = DM_CTRL;
            run_left = '0;
            row_pos  = '0;
            row_len  = ROW_BYTES_RESET;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected no item, got %0h", i_out_byte);
                    fail_count++;
                end else begin
                    e = expected_bytes.pop_front();
                    check_field("out_byte", e.data, i_out_byte);
                    check_field("last_of_burst", e.last, i_last_of_burst);
                    check_field("row_end", e.row_end, i_row_end);
                    check_field("overrun", e.overrun, i_overrun);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                row_len = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_stream_byte(i_in_byte);
        end
        o_pending    = expected_bytes.size();
        o_fail_count = fail_count;
    end

endmodule : pbrd_stream_checker

>>> dv/packbits_row_decoder_test.sv
// Testbench top for the PackBits row decoder: clock, reset, stream and row
// length stimulus with random stalls, watchdog and verdict.
// Depends on pbrd_pkg, packbits_row_decoder and pbrd_stream_checker.

module packbits_row_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pbrd_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SEG_ITEMS    = 12;
    localparam int NUM_SEGS     = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_of_burst;
    logic        o_row_end;
    logic        o_overrun;
    logic        o_cfg_ready;

    int fail_count;
    int pending;
    int in_idle_pct  = 34;
    int out_idle_pct = 58;
    int quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    packbits_row_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_burst (o_last_of_burst),
        .o_row_end       (o_row_end),
        .o_overrun       (o_overrun),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    pbrd_stream_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_last_of_burst (o_last_of_burst),
        .i_row_end       (o_row_end),
        .i_overrun       (o_overrun),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [7:0] literal_ctrl(int len);
        return 8'(len - 1);
    endfunction

    function automatic logic [7:0] repeat_ctrl(int count);
        return 8'(257 - count);
    endfunction

    // Called and returns at a falling edge; valid stays high on return
    task automatic send_stream_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Let every expected item out, then give queued no-output items time to go
    task automatic drain_decoder();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_row_bytes(input logic [15:0] len);
        drain_decoder();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random packet: mostly well-formed runs, some noise and no-ops
    task automatic send_random_packet(inout int sent);
        int sel;
        int len;
        sel = $urandom_range(99);
        if (sel < 6) begin
            send_stream_byte(8'($urandom_range(255)));
            sent++;
        end else if (sel < 12) begin
            send_stream_byte(NOP_CODE);
            sent++;
        end else if (sel < 56) begin
            len = ($urandom_range(99) < 4) ? 128 : $urandom_range(1, 8);
            send_stream_byte(literal_ctrl(len));
            repeat (len) send_stream_byte(8'($urandom_range(255)));
            sent += len + 1;
        end else begin
            send_stream_byte(repeat_ctrl($urandom_range(2, 128)));
            send_stream_byte(8'($urandom_range(255)));
            sent += 2;
        end
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default row length: capped 128-byte burst, no-op, literal extremes
        send_stream_byte(repeat_ctrl(128));
        send_stream_byte(8'h5A);
        send_stream_byte(NOP_CODE);
        send_stream_byte(literal_ctrl(1));
        send_stream_byte(8'hFF);
        send_stream_byte(literal_ctrl(2));
        send_stream_byte(8'h00);
        send_stream_byte(8'h80);
        send_stream_byte(repeat_ctrl(2));
        send_stream_byte(8'h3C);

        // Row shrunk below the position: literal closes the row at once,
        // then repeats past and exactly at the row end
        write_row_bytes(16'd3);
        send_stream_byte(literal_ctrl(5));
        send_stream_byte(8'h11);
        send_stream_byte(8'h22);
        send_stream_byte(8'h33);
        send_stream_byte(8'h44);
        send_stream_byte(8'h55);
        send_stream_byte(repeat_ctrl(4));
        send_stream_byte(8'h77);
        send_stream_byte(repeat_ctrl(3));
        send_stream_byte(8'h66);

        // One-byte rows
        write_row_bytes(16'd1);
        send_stream_byte(literal_ctrl(3));
        send_stream_byte(8'hA5);
        send_stream_byte(8'h5A);
        send_stream_byte(8'hC3);

        // Random segments over several row lengths and stall mixes
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 2)
                0: begin
                    in_idle_pct  = 34;
                    out_idle_pct = 58;
                end
                1: begin
                    in_idle_pct  = 58;
                    out_idle_pct = 34;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            case (seg)
                0: write_row_bytes(16'($urandom_range(1, 12)));
                1: write_row_bytes(16'hFFFF);
                2: write_row_bytes(16'd1);
                3: write_row_bytes(16'($urandom_range(2, 40)));
                4: write_row_bytes(16'd0);
                default: write_row_bytes(16'($urandom_range(1, 8)));
            endcase
            sent = 0;
            while (sent < SEG_ITEMS)
                send_random_packet(sent);
        end

        drain_decoder();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule : packbits_row_decoder_test
